// ===== rtl/core/mcarv_pkg.sv =====
package mcarv_pkg;

   // One request item: a start command or a random value for the next carve.
   typedef struct packed {
      logic        cmd;
      logic [30:0] random_value;
   } req_type;

   // One result item: the carved edge and the completion flag.
   typedef struct packed {
      logic [5:0] from_x;
      logic [5:0] from_y;
      logic [5:0] to_x;
      logic [5:0] to_y;
      logic       carved;
      logic       finished;
   } rsp_type;

   // Neighbor directions in the order in which they are tried.
   typedef enum logic [1:0] {
      DIR_DOWN,
      DIR_UP,
      DIR_RIGHT,
      DIR_LEFT
   } dir_type;

   // Outcome of the neighbor choice for one carve.
   typedef struct packed {
      logic    found;
      dir_type dir;
   } pick_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT,
      ST_CLEAR,
      ST_PROBE,
      ST_DECIDE,
      ST_POP,
      ST_FINISH
   } state_type;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_CARVE = 1'b1;

   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   localparam int COORD_W   = 6;
   localparam int DIM_W     = 7;
   localparam int CELL_W    = 2 * COORD_W;
   localparam int MAP_DEPTH = 4096;
   localparam int EDGE_W    = 12;
   localparam int NUM_DIRS  = 4;

endpackage

// ===== rtl/core/randomized_dfs_maze_carver.sv =====
// Randomized depth-first maze carver. A start item (cmd 0) latches the grid size from the
// grid_width and grid_height registers (0 counts as 1, above 64 as 64, and the area is kept
// within MAX_CELLS), clears the visited map over the grid and puts the walker on cell (0,0);
// it produces no result, and it sheds rows to meet MAX_CELLS only when MAX_CELLS is below 4096.
// Each carve item (cmd 1) produces one result with the edge from the walker's cell to a
// randomly chosen unvisited neighbor, tried in the order down, up, right, left, the choice
// being random_value modulo the number of open neighbors; finished is set on the last edge.
// A carve item takes longer for each dead-end cell it backtracks through, because the four
// neighbor visited bits are read one per cycle from a map with one read port and every
// backtrack step waits for one stack read. A carve item after the last edge, or before
// any start, returns carved 0 with finished 1. Items are taken one at a time; a new item
// is accepted while a result still waits on rsp_stall, and a result is held until the
// output register is free. Grid registers take effect at the next start item.
module randomized_dfs_maze_carver #(
   parameter int MAX_CELLS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  mcarv_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mcarv_pkg::rsp_type rsp_data,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [6:0]         csr_wdata
);

   // Only as many cells as the 64 by 64 coordinate space or MAX_CELLS allow can be on
   // the stack at once.
   localparam int CELL_LIMIT = (MAX_CELLS < 4096) ? MAX_CELLS : 4096;
   localparam int W_CAP_INT  = (MAX_CELLS < 64) ? MAX_CELLS : 64;
   localparam logic [mcarv_pkg::DIM_W-1:0] W_CAP = mcarv_pkg::DIM_W'(W_CAP_INT);
   localparam int SA_W = $clog2(CELL_LIMIT);
   localparam int SP_W = $clog2(CELL_LIMIT + 1);
   localparam logic [SP_W-1:0] SP_FULL = SP_W'(CELL_LIMIT);
   localparam int MAP_AW = $clog2(mcarv_pkg::MAP_DEPTH);

   mcarv_pkg::state_type state_ff, state_in;

   logic [mcarv_pkg::DIM_W-1:0]   grid_width_ff, grid_width_in;
   logic [mcarv_pkg::DIM_W-1:0]   grid_height_ff, grid_height_in;
   logic [mcarv_pkg::DIM_W-1:0]   run_w_ff, run_w_in;
   logic [mcarv_pkg::DIM_W-1:0]   run_h_ff, run_h_in;
   logic [mcarv_pkg::COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [mcarv_pkg::COORD_W-1:0] cur_y_ff, cur_y_in;
   logic [mcarv_pkg::COORD_W-1:0] clr_x_ff, clr_x_in;
   logic [mcarv_pkg::COORD_W-1:0] clr_y_ff, clr_y_in;
   logic [SP_W-1:0]               sp_ff, sp_in;
   logic [mcarv_pkg::EDGE_W-1:0]  edges_ff, edges_in;
   logic [2:0]                    probe_k_ff, probe_k_in;
   mcarv_pkg::dir_type            pend_dir_ff, pend_dir_in;
   logic                          pend_exist_ff, pend_exist_in;
   logic [3:0]                    open_mask_ff, open_mask_in;
   logic [1:0]                    rnd_low_ff, rnd_low_in;
   logic [9:0]                    rnd_sum_ff, rnd_sum_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   mcarv_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                          req_fire;
   logic                          rsp_fire;
   logic                          slot_free;
   logic [13:0]                   area;
   logic                          area_over;
   logic                          clr_last;
   logic [SP_W-1:0]               sp_dec;
   mcarv_pkg::pick_type           pick;
   logic [mcarv_pkg::CELL_W-1:0]  next_cell;

   logic                          map_we;
   logic [MAP_AW-1:0]             map_wr_addr;
   logic                          map_wr_data;
   logic [MAP_AW-1:0]             map_rd_addr;
   logic                          map_rd_data;

   logic                          stk_we;
   logic [mcarv_pkg::CELL_W-1:0]  stk_rd_data;

   function automatic logic [mcarv_pkg::DIM_W-1:0] clamp_dim(
      input logic [mcarv_pkg::DIM_W-1:0] v
   );
      logic [mcarv_pkg::DIM_W-1:0] r;
      if (v == '0) begin
         r = 7'd1;
      end else if (v > 7'd64) begin
         r = 7'd64;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic has_neighbor(
      input mcarv_pkg::dir_type          d,
      input logic [mcarv_pkg::COORD_W-1:0] x,
      input logic [mcarv_pkg::COORD_W-1:0] y,
      input logic [mcarv_pkg::DIM_W-1:0]   w,
      input logic [mcarv_pkg::DIM_W-1:0]   h
   );
      logic r;
      unique case (d)
         mcarv_pkg::DIR_DOWN:  r = ({1'b0, y} + 7'd1) < h;
         mcarv_pkg::DIR_UP:    r = (y != '0);
         mcarv_pkg::DIR_RIGHT: r = ({1'b0, x} + 7'd1) < w;
         mcarv_pkg::DIR_LEFT:  r = (x != '0);
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

   // Cells are addressed as {row, column}, so no multiply by the width is needed.
   function automatic logic [mcarv_pkg::CELL_W-1:0] neighbor(
      input mcarv_pkg::dir_type          d,
      input logic [mcarv_pkg::COORD_W-1:0] x,
      input logic [mcarv_pkg::COORD_W-1:0] y
   );
      logic [mcarv_pkg::CELL_W-1:0] r;
      unique case (d)
         mcarv_pkg::DIR_DOWN:  r = {y + 6'd1, x};
         mcarv_pkg::DIR_UP:    r = {y - 6'd1, x};
         mcarv_pkg::DIR_RIGHT: r = {y, x + 6'd1};
         mcarv_pkg::DIR_LEFT:  r = {y, x - 6'd1};
         default:              r = {y, x};
      endcase
      return r;
   endfunction

   assign req_stall = (state_ff != mcarv_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_fire  = rsp_valid_ff && !rsp_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign area      = run_w_ff * run_h_ff;
   assign area_over = int'(area) > MAX_CELLS;
   assign clr_last  = ({1'b0, clr_x_ff} == run_w_ff - 7'd1)
                   && ({1'b0, clr_y_ff} == run_h_ff - 7'd1);
   assign sp_dec    = sp_ff - SP_W'(1);
   assign next_cell = neighbor(pick.dir, cur_x_ff, cur_y_ff);

   // The visited map, one bit per {row, column}.
   mcarv_ram #(
      .WIDTH (1),
      .DEPTH (mcarv_pkg::MAP_DEPTH)
   ) u_visited (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_wr_addr),
      .wr_data (map_wr_data),
      .rd_addr (map_rd_addr),
      .rd_data (map_rd_data)
   );

   // The backtrack stack; pushes and pops never fall in the same cycle.
   mcarv_ram #(
      .WIDTH (mcarv_pkg::CELL_W),
      .DEPTH (CELL_LIMIT)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (sp_ff[SA_W-1:0]),
      .wr_data ({cur_y_ff, cur_x_ff}),
      .rd_addr (sp_dec[SA_W-1:0]),
      .rd_data (stk_rd_data)
   );

   mcarv_pick u_pick (
      .open_mask (open_mask_ff),
      .rnd_low   (rnd_low_ff),
      .rnd_sum   (rnd_sum_ff),
      .pick      (pick)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mcarv_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == mcarv_pkg::CMD_START) begin
                  state_in = mcarv_pkg::ST_LIMIT;
               end else if (edges_ff == '0) begin
                  state_in = mcarv_pkg::ST_FINISH;
               end else begin
                  state_in = mcarv_pkg::ST_PROBE;
               end
            end
         end
         mcarv_pkg::ST_LIMIT: begin
            if (!area_over) begin
               state_in = mcarv_pkg::ST_CLEAR;
            end
         end
         mcarv_pkg::ST_CLEAR: begin
            if (clr_last) begin
               state_in = mcarv_pkg::ST_IDLE;
            end
         end
         mcarv_pkg::ST_PROBE: begin
            if (probe_k_ff == 3'd4) begin
               state_in = mcarv_pkg::ST_DECIDE;
            end
         end
         mcarv_pkg::ST_DECIDE: begin
            if (pick.found) begin
               if (slot_free) begin
                  state_in = mcarv_pkg::ST_IDLE;
               end
            end else if (sp_ff == '0) begin
               // Walker stuck with an empty stack: the item ends without a result.
               state_in = mcarv_pkg::ST_IDLE;
            end else begin
               state_in = mcarv_pkg::ST_POP;
            end
         end
         mcarv_pkg::ST_POP: begin
            state_in = mcarv_pkg::ST_PROBE;
         end
         mcarv_pkg::ST_FINISH: begin
            if (slot_free) begin
               state_in = mcarv_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcarv_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath, memory controls and the output register.
   always_comb begin
      grid_width_in  = grid_width_ff;
      grid_height_in = grid_height_ff;
      run_w_in       = run_w_ff;
      run_h_in       = run_h_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      clr_x_in       = clr_x_ff;
      clr_y_in       = clr_y_ff;
      sp_in          = sp_ff;
      edges_in       = edges_ff;
      probe_k_in     = probe_k_ff;
      pend_dir_in    = pend_dir_ff;
      pend_exist_in  = pend_exist_ff;
      open_mask_in   = open_mask_ff;
      rnd_low_in     = rnd_low_ff;
      rnd_sum_in     = rnd_sum_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_fire;
      map_we         = 1'b0;
      map_wr_addr    = {cur_y_ff, cur_x_ff};
      map_wr_data    = 1'b1;
      map_rd_addr    = neighbor(mcarv_pkg::dir_type'(probe_k_ff[1:0]), cur_x_ff, cur_y_ff);
      stk_we         = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            mcarv_pkg::CSR_GRID_WIDTH:  grid_width_in  = csr_wdata;
            mcarv_pkg::CSR_GRID_HEIGHT: grid_height_in = csr_wdata;
            default:                    grid_width_in  = grid_width_ff;
         endcase
      end

      unique case (state_ff)
         mcarv_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_data.cmd == mcarv_pkg::CMD_START) begin
                  run_w_in = (clamp_dim(grid_width_ff) > W_CAP) ? W_CAP
                                                              : clamp_dim(grid_width_ff);
                  run_h_in = clamp_dim(grid_height_ff);
                  cur_x_in = '0;
                  cur_y_in = '0;
                  sp_in    = '0;
               end else begin
                  // Residues by 2 and 4 come from the low bits; the byte sum keeps
                  // the residue by 3.
                  rnd_low_in   = req_data.random_value[1:0];
                  rnd_sum_in   = {2'd0, req_data.random_value[7:0]}
                               + {2'd0, req_data.random_value[15:8]}
                               + {2'd0, req_data.random_value[23:16]}
                               + {3'd0, req_data.random_value[30:24]};
                  probe_k_in   = 3'd0;
                  open_mask_in = '0;
               end
            end
         end
         mcarv_pkg::ST_LIMIT: begin
            // Shed rows one at a time until the area fits in MAX_CELLS.
            if (area_over) begin
               run_h_in = run_h_ff - 7'd1;
            end else begin
               edges_in = area[mcarv_pkg::EDGE_W-1:0] - 12'd1;
               clr_x_in = '0;
               clr_y_in = '0;
            end
         end
         mcarv_pkg::ST_CLEAR: begin
            map_we      = 1'b1;
            map_wr_addr = {clr_y_ff, clr_x_ff};
            map_wr_data = 1'b0;
            if ({1'b0, clr_x_ff} == run_w_ff - 7'd1) begin
               clr_x_in = '0;
               clr_y_in = clr_y_ff + 6'd1;
            end else begin
               clr_x_in = clr_x_ff + 6'd1;
            end
         end
         mcarv_pkg::ST_PROBE: begin
            // Mark the walker's cell while the first neighbor read goes out; each
            // later cycle takes in the bit that the previous cycle asked for.
            if (probe_k_ff == 3'd0) begin
               map_we = 1'b1;
            end
            if (probe_k_ff != 3'd4) begin
               pend_dir_in   = mcarv_pkg::dir_type'(probe_k_ff[1:0]);
               pend_exist_in = has_neighbor(mcarv_pkg::dir_type'(probe_k_ff[1:0]),
                                            cur_x_ff, cur_y_ff, run_w_ff, run_h_ff);
               probe_k_in    = probe_k_ff + 3'd1;
            end
            if (probe_k_ff != 3'd0) begin
               open_mask_in[pend_dir_ff] = pend_exist_ff && !map_rd_data;
            end
         end
         mcarv_pkg::ST_DECIDE: begin
            if (pick.found) begin
               if (slot_free) begin
                  if (sp_ff < SP_FULL) begin
                     stk_we = 1'b1;
                     sp_in  = sp_ff + SP_W'(1);
                  end
                  edges_in             = edges_ff - 12'd1;
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.from_x   = cur_x_ff;
                  rsp_data_in.from_y   = cur_y_ff;
                  rsp_data_in.to_x     = next_cell[5:0];
                  rsp_data_in.to_y     = next_cell[11:6];
                  rsp_data_in.carved   = 1'b1;
                  rsp_data_in.finished = (edges_ff == 12'd1);
                  cur_x_in             = next_cell[5:0];
                  cur_y_in             = next_cell[11:6];
               end
            end else if (sp_ff != '0) begin
               // Dead end: the stack read at the top entry is issued this cycle.
               sp_in = sp_dec;
            end
         end
         mcarv_pkg::ST_POP: begin
            cur_x_in     = stk_rd_data[5:0];
            cur_y_in     = stk_rd_data[11:6];
            probe_k_in   = 3'd0;
            open_mask_in = '0;
         end
         mcarv_pkg::ST_FINISH: begin
            if (slot_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.from_x   = '0;
               rsp_data_in.from_y   = '0;
               rsp_data_in.to_x     = '0;
               rsp_data_in.to_y     = '0;
               rsp_data_in.carved   = 1'b0;
               rsp_data_in.finished = 1'b1;
            end
         end
         default: begin
            map_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mcarv_pkg::ST_IDLE;
         grid_width_ff  <= 7'd8;
         grid_height_ff <= 7'd8;
         run_w_ff       <= 7'd1;
         run_h_ff       <= 7'd1;
         cur_x_ff       <= '0;
         cur_y_ff       <= '0;
         sp_ff          <= '0;
         edges_ff       <= '0;
         probe_k_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         grid_width_ff  <= grid_width_in;
         grid_height_ff <= grid_height_in;
         run_w_ff       <= run_w_in;
         run_h_ff       <= run_h_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         sp_ff          <= sp_in;
         edges_ff       <= edges_in;
         probe_k_ff     <= probe_k_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      clr_x_ff      <= clr_x_in;
      clr_y_ff      <= clr_y_in;
      pend_dir_ff   <= pend_dir_in;
      pend_exist_ff <= pend_exist_in;
      open_mask_ff  <= open_mask_in;
      rnd_low_ff    <= rnd_low_in;
      rnd_sum_ff    <= rnd_sum_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // A carved edge always joins two cells that share a side.
   a_edge_adjacent: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.carved) |->
         ((rsp_data_ff.from_x == rsp_data_ff.to_x)
             && ((rsp_data_ff.from_y + 6'd1 == rsp_data_ff.to_y)
                 || (rsp_data_ff.to_y + 6'd1 == rsp_data_ff.from_y)))
         || ((rsp_data_ff.from_y == rsp_data_ff.to_y)
             && ((rsp_data_ff.from_x + 6'd1 == rsp_data_ff.to_x)
                 || (rsp_data_ff.to_x + 6'd1 == rsp_data_ff.from_x))))
      else $error("carved edge joins cells that are not neighbors");

   // Every carve that is committed takes exactly one edge off the count.
   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcarv_pkg::ST_DECIDE && pick.found && slot_free) |=>
         (edges_ff == $past(edges_ff) - 12'd1))
      else $error("edge count not decremented by a carve");

   // While edges remain, the walker stays inside the grid.
   a_walker_inside: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcarv_pkg::ST_IDLE && edges_ff != '0) |->
         ({1'b0, cur_x_ff} < run_w_ff && {1'b0, cur_y_ff} < run_h_ff))
      else $error("walker outside the grid");

   // On a connected grid with edges left, backtracking never runs the stack dry.
   a_never_stuck: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mcarv_pkg::ST_DECIDE && !pick.found) |-> (sp_ff != '0))
      else $error("walker stuck with an empty stack");

endmodule

// ===== rtl/core/mcarv_ram.sv =====
module mcarv_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mcarv_pick.sv =====
module mcarv_pick (
   input  logic [3:0]           open_mask,
   input  logic [1:0]           rnd_low,
   input  logic [9:0]           rnd_sum,
   output mcarv_pkg::pick_type  pick
);

   logic [8:0] fold1;
   logic [4:0] fold2;
   logic [2:0] fold3;
   logic [1:0] mod3;
   logic [2:0] count;
   logic [1:0] index;
   logic [2:0] seen;

   // The byte sum keeps the value modulo three; fold it down in base 256, base 16 and base 4,
   // all of which are also congruent to one.
   always_comb begin
      fold1 = {7'd0, rnd_sum[9:8]} + {1'b0, rnd_sum[7:0]};
      fold2 = {4'd0, fold1[8]} + {1'b0, fold1[7:4]} + {1'b0, fold1[3:0]};
      fold3 = {2'd0, fold2[4]} + {1'b0, fold2[3:2]} + {1'b0, fold2[1:0]};
      if (fold3 >= 3'd6) begin
         mod3 = 2'(fold3 - 3'd6);
      end else if (fold3 >= 3'd3) begin
         mod3 = 2'(fold3 - 3'd3);
      end else begin
         mod3 = fold3[1:0];
      end
   end

   always_comb begin
      count = {2'd0, open_mask[0]} + {2'd0, open_mask[1]}
            + {2'd0, open_mask[2]} + {2'd0, open_mask[3]};
      unique case (count)
         3'd1:    index = 2'd0;
         3'd2:    index = {1'b0, rnd_low[0]};
         3'd3:    index = mod3;
         default: index = rnd_low;
      endcase
   end

   // Take the open direction whose rank among the open ones equals the index.
   always_comb begin
      pick.found = 1'b0;
      pick.dir   = mcarv_pkg::DIR_DOWN;
      seen       = 3'd0;
      for (int i = 0; i < mcarv_pkg::NUM_DIRS; i++) begin
         if (open_mask[i]) begin
            if (!pick.found && seen == {1'b0, index}) begin
               pick.found = 1'b1;
               pick.dir   = mcarv_pkg::dir_type'(2'(i));
            end
            seen = seen + 3'd1;
         end
      end
   end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the randomized depth-first maze carver.
//
// Every request item is driven through the valid/stall handshake. The scoreboard keeps its
// own copy of the walker: the visited map, the backtrack stack, the current cell and the
// count of edges still to carve. It predicts the result of each accepted request and checks
// the results that the block delivers field by field, in order. The grid registers are
// written only while the block is idle, between runs of items.
module tb;

   localparam int CELL_LIMIT   = 4096;
   localparam int RANDOM_ITEMS = 900;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int REPORT_CAP   = 60;

   // Scoreboard: mirrors the carver's state and holds the edges still expected, oldest first.
   class maze_scoreboard;
      bit                 visited[CELL_LIMIT];
      int unsigned        trail[CELL_LIMIT];
      int unsigned        depth;
      int unsigned        walker;
      int unsigned        edges_left;
      int unsigned        run_w;
      int unsigned        run_h;
      int unsigned        reg_w;
      int unsigned        reg_h;
      mcarv_pkg::rsp_type pending_edges[$];
      int                 errors;

      function new();
         visited = '{default: 1'b0};
         trail = '{default: 0};
         depth = 0;
         walker = 0;
         edges_left = 0;
         run_w = 1;
         run_h = 1;
         reg_w = 8;
         reg_h = 8;
         errors = 0;
      endfunction

      // A register value of zero means one cell, anything above 64 means 64.
      function int unsigned clamp_dim(int unsigned v);
         if (v == 0) return 1;
         if (v > 64) return 64;
         return v;
      endfunction

      function void note_config(logic idx, logic [mcarv_pkg::DIM_W-1:0] value);
         if (idx == mcarv_pkg::CSR_GRID_WIDTH) reg_w = 32'(value);
         else reg_h = 32'(value);
      endfunction

      function void note_request(mcarv_pkg::req_type item);
         int unsigned        cand[mcarv_pkg::NUM_DIRS];
         int unsigned        n;
         int unsigned        x;
         int unsigned        y;
         int unsigned        next_cell;
         int unsigned        w;
         int unsigned        h;
         mcarv_pkg::rsp_type r;
         if (item.cmd == mcarv_pkg::CMD_START) begin
            w = clamp_dim(reg_w);
            h = clamp_dim(reg_h);
            if (w > CELL_LIMIT) w = CELL_LIMIT;
            if (w * h > CELL_LIMIT) h = CELL_LIMIT / w;
            run_w = w;
            run_h = h;
            visited = '{default: 1'b0};
            depth = 0;
            walker = 0;
            edges_left = w * h - 1;
            return;
         end
         r = '0;
         if (edges_left == 0) begin
            r.finished = 1'b1;
            pending_edges.push_back(r);
            return;
         end
         // Backtrack until the walker stands on a cell with an unvisited neighbor.
         while (1) begin
            visited[walker] = 1'b1;
            x = walker % run_w;
            y = walker / run_w;
            n = 0;
            if (y + 1 < run_h && !visited[walker + run_w]) begin
               cand[n] = walker + run_w;
               n++;
            end
            if (y > 0 && !visited[walker - run_w]) begin
               cand[n] = walker - run_w;
               n++;
            end
            if (x + 1 < run_w && !visited[walker + 1]) begin
               cand[n] = walker + 1;
               n++;
            end
            if (x > 0 && !visited[walker - 1]) begin
               cand[n] = walker - 1;
               n++;
            end
            if (n > 0) break;
            if (depth == 0) return;
            depth--;
            walker = trail[depth];
         end
         next_cell = cand[item.random_value % n];
         if (depth < CELL_LIMIT) begin
            trail[depth] = walker;
            depth++;
         end
         edges_left--;
         r.from_x = mcarv_pkg::COORD_W'(walker % run_w);
         r.from_y = mcarv_pkg::COORD_W'(walker / run_w);
         r.to_x = mcarv_pkg::COORD_W'(next_cell % run_w);
         r.to_y = mcarv_pkg::COORD_W'(next_cell / run_w);
         r.carved = 1'b1;
         r.finished = (edges_left == 0);
         walker = next_cell;
         pending_edges.push_back(r);
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      endfunction

      function void check_result(mcarv_pkg::rsp_type got);
         mcarv_pkg::rsp_type want;
         if (pending_edges.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
               $display("%0t: unexpected result, expected none, actual %h", $time, got);
            return;
         end
         want = pending_edges.pop_front();
         if (got.from_x !== want.from_x)
            flag("from_x", 32'(want.from_x), 32'(got.from_x));
         if (got.from_y !== want.from_y)
            flag("from_y", 32'(want.from_y), 32'(got.from_y));
         if (got.to_x !== want.to_x)
            flag("to_x", 32'(want.to_x), 32'(got.to_x));
         if (got.to_y !== want.to_y)
            flag("to_y", 32'(want.to_y), 32'(got.to_y));
         if (got.carved !== want.carved)
            flag("carved", 32'(want.carved), 32'(got.carved));
         if (got.finished !== want.finished)
            flag("finished", 32'(want.finished), 32'(got.finished));
      endfunction

      function int pending();
         return pending_edges.size();
      endfunction
   endclass

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_stall;
   mcarv_pkg::req_type          req_data = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   mcarv_pkg::rsp_type          rsp_data;
   logic                        csr_we = 1'b0;
   logic                        csr_index = mcarv_pkg::CSR_GRID_WIDTH;
   logic [mcarv_pkg::DIM_W-1:0] csr_wdata = '0;

   maze_scoreboard sb;
   int             cycles = 0;
   int             idle_pct = 25;
   int             sent = 0;

   randomized_dfs_maze_carver #(
      .MAX_CELLS(CELL_LIMIT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The watchdog ends a hung run. Its limit is far above the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("randomized_dfs_maze_carver verification failed");
         $finish;
      end
   end

   // The receiver stalls at random. With idle_pct at zero it takes every result at once.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   // Results are sampled at the edge where they are accepted, before any update lands.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Drives one request item and returns at the edge where the carver accepts it. The
   // valid line stays high when the next item follows without a gap.
   task automatic send_item(input logic cmd, input logic [30:0] value);
      int gap;
      mcarv_pkg::req_type item;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      // Now and then a long pause, so that gaps also land inside long backtracks.
      if (idle_pct > 0 && $urandom_range(49) == 0) gap += $urandom_range(30, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.cmd = cmd;
      item.random_value = value;
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
      sent++;
   endtask

   // Writes the width register, then the height register. Only called while idle.
   task automatic write_grid(input logic [mcarv_pkg::DIM_W-1:0] w_val,
                             input logic [mcarv_pkg::DIM_W-1:0] h_val);
      req_valid <= 1'b0;
      csr_we <= 1'b1;
      csr_index <= mcarv_pkg::CSR_GRID_WIDTH;
      csr_wdata <= w_val;
      @(posedge clock);
      sb.note_config(mcarv_pkg::CSR_GRID_WIDTH, w_val);
      csr_index <= mcarv_pkg::CSR_GRID_HEIGHT;
      csr_wdata <= h_val;
      @(posedge clock);
      sb.note_config(mcarv_pkg::CSR_GRID_HEIGHT, h_val);
      csr_we <= 1'b0;
   endtask

   // Waits for every expected result, then long enough for a start item to finish clearing
   // the visited map, since a start produces no result of its own.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (2 * sb.run_w * sb.run_h + 64) @(posedge clock);
   endtask

   function automatic logic [30:0] pick_value();
      if ($urandom_range(9) < 3) return 31'($urandom_range(3));
      return 31'($urandom);
   endfunction

   initial begin
      int unsigned                 cells;
      int unsigned                 carves;
      int                          phase;
      int                          base;
      int unsigned                 r;
      logic [mcarv_pkg::DIM_W-1:0] w_val;
      logic [mcarv_pkg::DIM_W-1:0] h_val;
      logic                        cmd;

      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Carves before any start report finished with no edge. Then an 8 by 8 maze from the
      // reset register values is begun with the extremes of the random value.
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0000);
      send_item(mcarv_pkg::CMD_CARVE, 31'h7FFF_FFFF);
      send_item(mcarv_pkg::CMD_START, 31'h7FFF_FFFF);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0000);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0001);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0002);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0003);
      send_item(mcarv_pkg::CMD_CARVE, 31'h7FFF_FFFF);
      send_item(mcarv_pkg::CMD_CARVE, 31'h2AAA_AAAA);
      send_item(mcarv_pkg::CMD_CARVE, 31'h5555_5555);
      settle();

      // A register write in the middle of a maze must not disturb it; the new 2 by 2 size
      // only applies from the next start. The last carve comes after the final edge.
      write_grid(7'd2, 7'd2);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0001);
      send_item(mcarv_pkg::CMD_CARVE, 31'h4000_0000);
      send_item(mcarv_pkg::CMD_START, 31'h0000_0000);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0002);
      send_item(mcarv_pkg::CMD_CARVE, 31'h1234_5678);
      send_item(mcarv_pkg::CMD_CARVE, 31'h7FFF_FFFE);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0001);
      settle();

      // Zero in both registers gives a single cell: the first carve is already finished.
      write_grid(7'd0, 7'd0);
      send_item(mcarv_pkg::CMD_START, 31'h0000_0000);
      send_item(mcarv_pkg::CMD_CARVE, 31'h0000_0000);
      send_item(mcarv_pkg::CMD_CARVE, 31'h7FFF_FFFF);
      settle();

      // Random mazes. Most are small and carved to the end, with a few extra carves after the
      // last edge. Some are abandoned early, and a little noise restarts a maze in flight.
      // The first two runs use the largest grid but carve only part of it.
      base = sent;
      phase = 0;
      while (sent - base < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (phase == 0) begin
            w_val = 7'd127;
            h_val = 7'd127;
         end else if (phase == 1) begin
            w_val = 7'd64;
            h_val = 7'd64;
         end else if (r < 55) begin
            w_val = 7'($urandom_range(6, 1));
            h_val = 7'($urandom_range(6, 1));
         end else if (r < 70) begin
            w_val = $urandom_range(1) ? 7'd64 : 7'($urandom_range(127, 65));
            h_val = 7'($urandom_range(2, 1));
            if ($urandom_range(1)) {w_val, h_val} = {h_val, w_val};
         end else if (r < 80) begin
            w_val = $urandom_range(1) ? 7'd0 : 7'($urandom_range(127, 65));
            h_val = $urandom_range(1) ? 7'd0 : 7'($urandom_range(4, 1));
         end else if (r < 95) begin
            w_val = 7'($urandom_range(12, 7));
            h_val = 7'($urandom_range(12, 7));
         end else begin
            w_val = 7'($urandom_range(127));
            h_val = 7'($urandom_range(3, 1));
         end
         write_grid(w_val, h_val);
         cells = sb.clamp_dim(32'(w_val)) * sb.clamp_dim(32'(h_val));
         send_item(mcarv_pkg::CMD_START, pick_value());
         carves = cells - 1 + $urandom_range(2);
         if (cells > 300) carves = $urandom_range(160, 100);
         else if ($urandom_range(9) == 0) carves = $urandom_range(cells);
         for (int k = 0; k < carves; k++) begin
            // A long calm stretch in the middle: neither side idles at all.
            idle_pct = (sent - base >= 350 && sent - base < 550) ? 0 : 25;
            cmd = ($urandom_range(49) == 0) ? mcarv_pkg::CMD_START : mcarv_pkg::CMD_CARVE;
            send_item(cmd, pick_value());
         end
         settle();
         phase++;
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("randomized_dfs_maze_carver verification clean");
      end else begin
         $display("randomized_dfs_maze_carver verification failed");
      end
      $finish;
   end

endmodule
